### rtl/ladder_logic_block_evaluator_core_defines.svh
// Assertion helpers for the RTL, included by the evaluator core.
`ifndef LADDER_LOGIC_BLOCK_EVALUATOR_CORE_DEFINES_SVH
`define LADDER_LOGIC_BLOCK_EVALUATOR_CORE_DEFINES_SVH

// Checked while out of reset.
`define LLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define LLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/lle_pkg.sv
package lle_pkg;

  localparam int MaxBlockSlots = 32;
  localparam int SlotW         = $clog2(MaxBlockSlots);
  localparam int SrcW          = SlotW + 1;
  localparam int CountW        = 6;
  localparam int IoBits        = 8;
  localparam int IoW           = $clog2(IoBits);
  localparam int TimeW         = 32;
  localparam int KindW         = 4;

  typedef enum logic [KindW-1:0] {
    KIND_NO      = 4'd0,
    KIND_NC      = 4'd1,
    KIND_COIL    = 4'd2,
    KIND_AND     = 4'd3,
    KIND_OR      = 4'd4,
    KIND_NOT     = 4'd5,
    KIND_TON     = 4'd6,
    KIND_TOF     = 4'd7,
    KIND_SET     = 4'd8,
    KIND_RESET   = 4'd9,
    KIND_TRUE    = 4'd10,
    KIND_FALSE   = 4'd11
  } kind_e;

  // read request to the slot store, issued on the accept edge
  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] addr_a;
    logic [SlotW-1:0] addr_b;
    logic [SlotW-1:0] addr_t;
  } rd_t;

  // write back of one evaluated block
  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] slot;
    logic             value;
    logic             tmr_en;
    logic             running;
    logic [TimeW-1:0] start;
  } wr_t;

  // resolved read data, valid in the cycle after the request
  typedef struct packed {
    logic             val_a;
    logic             val_b;
    logic             running;
    logic [TimeW-1:0] start;
  } rsp_t;

endpackage

### rtl/lle_in_if.sv
interface lle_in_if;
  logic                             valid;
  logic                             ready;
  logic [lle_pkg::SlotW-1:0]        block_index;
  logic [lle_pkg::KindW-1:0]        block_type;
  logic signed [lle_pkg::SrcW-1:0]  source_a;
  logic signed [lle_pkg::SrcW-1:0]  source_b;
  logic [lle_pkg::IoW-1:0]          io_index;
  logic [lle_pkg::TimeW-1:0]        preset_ms;
  logic [lle_pkg::TimeW-1:0]        now_ms;
  logic [lle_pkg::IoBits-1:0]       input_bits;

  modport source (
    output valid, block_index, block_type, source_a, source_b, io_index,
           preset_ms, now_ms, input_bits,
    input  ready
  );
  modport sink (
    input  valid, block_index, block_type, source_a, source_b, io_index,
           preset_ms, now_ms, input_bits,
    output ready
  );
endinterface

### rtl/lle_out_if.sv
interface lle_out_if;
  logic                       valid;
  logic                       ready;
  logic                       block_result;
  logic [lle_pkg::IoBits-1:0] output_bits;

  modport source (output valid, block_result, output_bits, input ready);
  modport sink (input valid, block_result, output_bits, output ready);
endinterface

### rtl/lle_cfg_if.sv
interface lle_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lle_pkg::CountW-1:0] block_count;

  modport source (output valid, block_count, input ready);
  modport sink (input valid, block_count, output ready);
endinterface

### rtl/lle_store.sv
module lle_store (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  lle_pkg::rd_t  rd_i,
  input  lle_pkg::wr_t  wr_i,
  output lle_pkg::rsp_t rsp_o
);
  import lle_pkg::*;

  logic             val_mem [MaxBlockSlots];
  logic [TimeW:0]   tmr_mem [MaxBlockSlots];

  logic [MaxBlockSlots-1:0] val_vld_q, tmr_vld_q;

  logic [SlotW-1:0] a_addr_q, b_addr_q, t_addr_q;
  logic             a_data_q, b_data_q;
  logic [TimeW:0]   t_data_q;
  logic             a_vld_q, b_vld_q, t_vld_q;
  wr_t              fwd_q;

  logic hit_a, hit_b, hit_t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_vld_q <= '0;
      tmr_vld_q <= '0;
    end else if (clear_i) begin
      val_vld_q <= '0;
      tmr_vld_q <= '0;
    end else begin
      if (wr_i.en) val_vld_q[wr_i.slot] <= 1'b1;
      if (wr_i.en && wr_i.tmr_en) tmr_vld_q[wr_i.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) val_mem[wr_i.slot] <= wr_i.value;
    if (wr_i.en && wr_i.tmr_en) tmr_mem[wr_i.slot] <= {wr_i.running, wr_i.start};
    if (rd_i.en) begin
      a_data_q <= val_mem[rd_i.addr_a];
      b_data_q <= val_mem[rd_i.addr_b];
      t_data_q <= tmr_mem[rd_i.addr_t];
      a_vld_q  <= val_vld_q[rd_i.addr_a];
      b_vld_q  <= val_vld_q[rd_i.addr_b];
      t_vld_q  <= tmr_vld_q[rd_i.addr_t];
      a_addr_q <= rd_i.addr_a;
      b_addr_q <= rd_i.addr_b;
      t_addr_q <= rd_i.addr_t;
    end
  end

  // a write landing on the same edge as the read is not seen by the array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= '0;
    end else if (rd_i.en) begin
      fwd_q <= wr_i;
    end
  end

  assign hit_a = fwd_q.en && (fwd_q.slot == a_addr_q);
  assign hit_b = fwd_q.en && (fwd_q.slot == b_addr_q);
  assign hit_t = fwd_q.en && fwd_q.tmr_en && (fwd_q.slot == t_addr_q);

  always_comb begin
    rsp_o.val_a   = hit_a ? fwd_q.value : (a_vld_q & a_data_q);
    rsp_o.val_b   = hit_b ? fwd_q.value : (b_vld_q & b_data_q);
    rsp_o.running = hit_t ? fwd_q.running : (t_vld_q & t_data_q[TimeW]);
    rsp_o.start   = hit_t ? fwd_q.start : t_data_q[TimeW-1:0];
  end

endmodule

### rtl/ladder_logic_block_evaluator_core.sv
// Channel  Dir  Words carried
// in_i     in   one ladder block: index, kind, sources, io bit, preset, time, inputs
// out_o    out  block result and output register after that block
// cfg_i    in   block_count, clears the slot store
//
// One block per cycle sustained while the output is not stalled; the output word is registered when stage 2 fires.
// Stage 1 reads the slot store (synchronous RAM); stage 2 evaluates
// and writes back, with the same-edge write forwarded into the next read.
// Reset clears the per-slot valid bits at once, so no clearing pass is needed.
// A stalled output holds stage 2, and input ready drops while stage 2 is full and held.
module ladder_logic_block_evaluator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  lle_in_if.sink    in_i,
  lle_out_if.source out_o,
  lle_cfg_if.sink   cfg_i
);
  import lle_pkg::*;

  `include "ladder_logic_block_evaluator_core_defines.svh"

  logic [CountW-1:0] count_q;
  logic [IoBits-1:0] out_reg_q, out_reg_d;

  logic              s1_vld_q;
  kind_e             s1_kind_q;
  logic [SlotW-1:0]  s1_slot_q;
  logic [SrcW-1:0]   s1_src_a_q, s1_src_b_q;
  logic [IoW-1:0]    s1_io_q;
  logic [TimeW-1:0]  s1_delay_q, s1_now_q;
  logic [IoBits-1:0] s1_inputs_q;

  logic              out_vld_q;
  logic              out_result_q;
  logic [IoBits-1:0] out_bits_q;

  logic in_acc, s1_fire;
  logic a, b, result;
  logic run_n;
  logic [TimeW-1:0] start_fresh, start_n, elapsed;
  logic tmr_wr;

  rd_t  rd;
  wr_t  wr;
  rsp_t rsp;

  assign s1_fire    = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s1_fire;
  assign in_acc     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_i.valid) begin
      count_q <= cfg_i.block_count;
    end
  end

  always_comb begin
    rd.en     = in_acc;
    rd.addr_a = in_i.source_a[SlotW-1:0];
    rd.addr_b = in_i.source_b[SlotW-1:0];
    rd.addr_t = in_i.block_index;
  end

  lle_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_i.valid),
    .rd_i    (rd),
    .wr_i    (wr),
    .rsp_o   (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q   <= kind_e'(in_i.block_type);
      s1_slot_q   <= in_i.block_index;
      s1_src_a_q  <= in_i.source_a;
      s1_src_b_q  <= in_i.source_b;
      s1_io_q     <= in_i.io_index;
      s1_delay_q  <= in_i.preset_ms;
      s1_now_q    <= in_i.now_ms;
      s1_inputs_q <= in_i.input_bits;
    end
  end

  // negative or past the loaded program reads false
  assign a = !s1_src_a_q[SrcW-1] && (CountW'(s1_src_a_q[SlotW-1:0]) < count_q) && rsp.val_a;
  assign b = !s1_src_b_q[SrcW-1] && (CountW'(s1_src_b_q[SlotW-1:0]) < count_q) && rsp.val_b;

  assign start_fresh = rsp.running ? rsp.start : s1_now_q;
  assign elapsed     = s1_now_q - start_fresh;

  always_comb begin
    result    = 1'b0;
    out_reg_d = out_reg_q;
    run_n     = rsp.running;
    start_n   = rsp.start;
    tmr_wr    = 1'b0;
    unique case (s1_kind_q)
      KIND_NO:   result = s1_inputs_q[s1_io_q];
      KIND_NC:   result = !s1_inputs_q[s1_io_q];
      KIND_COIL: begin
        result             = a;
        out_reg_d[s1_io_q] = a;
      end
      KIND_AND:  result = a && b;
      KIND_OR:   result = a || b;
      KIND_NOT:  result = !a;
      KIND_TON: begin
        tmr_wr = 1'b1;
        if (a) begin
          run_n   = 1'b1;
          start_n = start_fresh;
          result  = elapsed >= s1_delay_q;
        end else begin
          run_n  = 1'b0;
          result = 1'b0;
        end
      end
      KIND_TOF: begin
        tmr_wr = 1'b1;
        if (a) begin
          run_n  = 1'b0;
          result = 1'b1;
        end else begin
          run_n   = 1'b1;
          start_n = start_fresh;
          result  = elapsed < s1_delay_q;
        end
      end
      KIND_SET: begin
        if (a) out_reg_d[s1_io_q] = 1'b1;
        result = out_reg_d[s1_io_q];
      end
      KIND_RESET: begin
        if (a) out_reg_d[s1_io_q] = 1'b0;
        result = out_reg_d[s1_io_q];
      end
      KIND_TRUE: result = 1'b1;
      default:   result = 1'b0;
    endcase
  end

  always_comb begin
    wr.en      = s1_fire;
    wr.slot    = s1_slot_q;
    wr.value   = result;
    wr.tmr_en  = tmr_wr;
    wr.running = run_n;
    wr.start   = start_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_reg_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        out_reg_q <= out_reg_d;
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_result_q <= result;
      out_bits_q   <= out_reg_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.block_result = out_result_q;
  assign out_o.output_bits  = out_bits_q;

  `LLE_ASSERT(a_fire_gives_word, s1_fire |=> out_vld_q,
              "evaluated block produced no output word")
  `LLE_ASSERT(a_outreg_only_on_fire, !s1_fire |=> $stable(out_reg_q),
              "output register moved without an evaluation")
  `LLE_ASSERT(a_coil_drives_bit,
              (s1_fire && s1_kind_q == KIND_COIL) |=>
                (out_reg_q[$past(s1_io_q)] == out_result_q),
              "coil result differs from driven bit")
  `LLE_ASSERT_ALWAYS(a_reset_empty, $rose(rst_ni) |-> (!out_vld_q && !s1_vld_q),
                     "pipeline not empty after reset")

endmodule

### tb/tb_ladder_logic_block_evaluator_core.sv
`timescale 1ns / 1ps

module tb_ladder_logic_block_evaluator_core;
  import lle_pkg::*;

  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic [KindW-1:0]  kind;
    logic [SrcW-1:0]   src_a;
    logic [SrcW-1:0]   src_b;
    logic [IoW-1:0]    io;
    logic [TimeW-1:0]  preset_ms;
    logic [TimeW-1:0]  scan_ms;
    logic [IoBits-1:0] inputs;
  } blk_t;

  typedef struct packed {
    logic              level;
    logic [IoBits-1:0] outs;
  } result_t;

  typedef struct packed {
    blk_t    blk;
    logic    fixed;
    result_t want;
  } dir_row_t;

  localparam int NumDirRows = 25;
  localparam int CountRow   = 3;   // block_count goes to 32 before this row
  localparam int NumPhases  = 6;
  localparam int PhaseItems = 90;

  // rows 0..2 run with block_count = 0 straight out of reset
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{'{5'd0,  KIND_TRUE,  6'd0,  6'd0,  3'd0, 32'd0,  32'd0,  8'h00}, 1'b1, '{1'b1, 8'h00}},
    '{'{5'd1,  KIND_COIL,  6'd0,  6'd0,  3'd7, 32'd0,  32'd0,  8'h00}, 1'b1, '{1'b0, 8'h00}},
    '{'{5'd2,  KIND_NO,    6'd0,  6'd0,  3'd7, 32'd0,  32'd0,  8'h80}, 1'b1, '{1'b1, 8'h00}},
    '{'{5'd0,  KIND_TRUE,  6'd0,  6'd0,  3'd0, 32'd0,  32'd0,  8'h00}, 1'b1, '{1'b1, 8'h00}},
    '{'{5'd1,  KIND_COIL,  6'd0,  6'd0,  3'd0, 32'd0,  32'd0,  8'h00}, 1'b1, '{1'b1, 8'h01}},
    '{'{5'd31, KIND_COIL,  6'd0,  6'd0,  3'd7, 32'd0,  32'd0,  8'h00}, 1'b1, '{1'b1, 8'h81}},
    '{'{5'd2,  KIND_NC,    6'd0,  6'd0,  3'd3, 32'd0,  32'd0,  8'hFF}, 1'b1, '{1'b0, 8'h81}},
    '{'{5'd3,  KIND_NC,    6'd0,  6'd0,  3'd3, 32'd0,  32'd0,  8'h00}, 1'b1, '{1'b1, 8'h81}},
    '{'{5'd4,  KIND_AND,   6'd0,  6'd3,  3'd0, 32'd0,  32'd0,  8'h00}, 1'b0, '{1'b0, 8'h00}},
    // negative and most negative sources read false
    '{'{5'd5,  KIND_OR,    6'h3F, 6'd2,  3'd0, 32'd0,  32'd0,  8'h00}, 1'b0, '{1'b0, 8'h00}},
    '{'{5'd6,  KIND_NOT,   6'h20, 6'h20, 3'd0, 32'd0,  32'd0,  8'h00}, 1'b0, '{1'b0, 8'h00}},
    '{'{5'd7,  KIND_SET,   6'd0,  6'd0,  3'd4, 32'd0,  32'd0,  8'h00}, 1'b0, '{1'b0, 8'h00}},
    '{'{5'd8,  KIND_RESET, 6'd0,  6'd0,  3'd0, 32'd0,  32'd0,  8'h00}, 1'b0, '{1'b0, 8'h00}},
    '{'{5'd9,  KIND_FALSE, 6'd0,  6'd0,  3'd0, 32'd0,  32'd0,  8'hFF}, 1'b0, '{1'b0, 8'h00}},
    // codes past the last kind act as constant false
    '{'{5'd10, 4'd15,      6'd0,  6'd0,  3'd0, 32'd0,  32'd0,  8'hFF}, 1'b0, '{1'b0, 8'h00}},
    '{'{5'd11, 4'd12,      6'd0,  6'd0,  3'd0, 32'd0,  32'd0,  8'hFF}, 1'b0, '{1'b0, 8'h00}},
    // on-delay across the 32-bit wrap: elapsed exactly the preset
    '{'{5'd12, KIND_TON,   6'd0,  6'd0,  3'd0, 32'd100, 32'hFFFF_FFC0, 8'h00}, 1'b0,
      '{1'b0, 8'h00}},
    '{'{5'd12, KIND_TON,   6'd0,  6'd0,  3'd0, 32'd100, 32'h0000_0024, 8'h00}, 1'b0,
      '{1'b0, 8'h00}},
    '{'{5'd13, KIND_TOF,   6'd1,  6'd0,  3'd0, 32'd5,  32'd0,  8'h00}, 1'b0, '{1'b0, 8'h00}},
    '{'{5'd13, KIND_TOF,   6'd9,  6'd0,  3'd0, 32'hFFFF_FFFF, 32'd0, 8'h00}, 1'b0,
      '{1'b0, 8'h00}},
    '{'{5'd13, KIND_TOF,   6'd9,  6'd0,  3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 8'h00}, 1'b0,
      '{1'b0, 8'h00}},
    '{'{5'd14, KIND_TON,   6'd0,  6'd0,  3'd0, 32'd0,  32'hFFFF_FFFF, 8'h00}, 1'b0,
      '{1'b0, 8'h00}},
    '{'{5'd15, KIND_TOF,   6'h3F, 6'd0,  3'd0, 32'd0,  32'd0,  8'h00}, 1'b0, '{1'b0, 8'h00}},
    '{'{5'd16, KIND_TON,   6'd0,  6'd0,  3'd0, 32'hFFFF_FFFF, 32'd123, 8'h00}, 1'b0,
      '{1'b0, 8'h00}},
    '{'{5'd17, KIND_OR,    6'd31, 6'd30, 3'd0, 32'd0,  32'd0,  8'h00}, 1'b0, '{1'b0, 8'h00}}
  };

  localparam logic [CountW-1:0] PhaseCount [NumPhases] = '{
    6'd32, 6'd1, 6'd0, 6'd63, 6'd7, 6'd20
  };
  localparam int PhaseIdle  [NumPhases] = '{0, 30, 15, 50, 20, 0};
  localparam int PhaseStall [NumPhases] = '{0, 30, 50, 10, 20, 0};

  logic clk;
  logic rst_n;

  lle_in_if  in_if ();
  lle_out_if out_if ();
  lle_cfg_if cfg_if ();

  ladder_logic_block_evaluator_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // shadow copy of the block state
  logic [CountW-1:0] blk_count;
  logic              slot_val  [MaxBlockSlots];
  logic              tmr_run   [MaxBlockSlots];
  logic [TimeW-1:0]  tmr_start [MaxBlockSlots];
  logic [IoBits-1:0] out_reg;

  result_t pending_results[$];
  int      mismatch_count;
  int      idle_pct;
  int      stall_pct;
  int      stall_left;
  logic    fix_en;
  result_t fix_want;
  blk_t    prog [16];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("ladder_logic_block_evaluator_core test failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void load_count(input logic [CountW-1:0] cnt);
    blk_count = cnt;
    for (int i = 0; i < MaxBlockSlots; i++) begin
      slot_val[i]  = 1'b0;
      tmr_run[i]   = 1'b0;
      tmr_start[i] = '0;
    end
  endfunction

  function automatic logic src_level(input logic [SrcW-1:0] raw);
    int lim;
    lim = (blk_count > MaxBlockSlots) ? MaxBlockSlots : int'(blk_count);
    if (raw[SrcW-1]) return 1'b0;
    if (int'(raw) >= lim) return 1'b0;
    return slot_val[raw[SlotW-1:0]];
  endfunction

  function automatic result_t eval_block(input blk_t b);
    logic             a;
    logic             c;
    logic             v;
    logic [SlotW-1:0] s;
    logic [TimeW-1:0] elapsed;
    result_t          r;
    s = b.slot;
    a = src_level(b.src_a);
    c = src_level(b.src_b);
    v = 1'b0;
    case (b.kind)
      KIND_NO:   v = b.inputs[b.io];
      KIND_NC:   v = !b.inputs[b.io];
      KIND_COIL: begin
        v = a;
        out_reg[b.io] = a;
      end
      KIND_AND:  v = a & c;
      KIND_OR:   v = a | c;
      KIND_NOT:  v = !a;
      KIND_TON: begin
        if (a) begin
          if (!tmr_run[s]) begin
            tmr_run[s]   = 1'b1;
            tmr_start[s] = b.scan_ms;
          end
          elapsed = b.scan_ms - tmr_start[s];
          v = (elapsed >= b.preset_ms);
        end else begin
          tmr_run[s] = 1'b0;
        end
      end
      KIND_TOF: begin
        if (a) begin
          tmr_run[s] = 1'b0;
          v = 1'b1;
        end else begin
          if (!tmr_run[s]) begin
            tmr_run[s]   = 1'b1;
            tmr_start[s] = b.scan_ms;
          end
          elapsed = b.scan_ms - tmr_start[s];
          v = (elapsed < b.preset_ms);
        end
      end
      KIND_SET: begin
        if (a) out_reg[b.io] = 1'b1;
        v = out_reg[b.io];
      end
      KIND_RESET: begin
        if (a) out_reg[b.io] = 1'b0;
        v = out_reg[b.io];
      end
      KIND_TRUE: v = 1'b1;
      default:   v = 1'b0;
    endcase
    slot_val[s] = v;
    r.level = v;
    r.outs  = out_reg;
    return r;
  endfunction

  // predict on accept, check on result, track config writes
  always @(posedge clk) begin
    blk_t    seen;
    result_t got;
    result_t want;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) load_count(cfg_if.block_count);
      if (out_if.valid && out_if.ready) begin
        got.level = out_if.block_result;
        got.outs  = out_if.output_bits;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected word res=%0b outs=%02h",
                                    got.level, got.outs));
        end else begin
          want = pending_results.pop_front();
          if (got.level !== want.level)
            report_mismatch($sformatf("block_result %0b, want %0b", got.level, want.level));
          if (got.outs !== want.outs)
            report_mismatch($sformatf("output_bits %02h, want %02h", got.outs, want.outs));
        end
      end
      if (in_if.valid && in_if.ready) begin
        seen.slot      = in_if.block_index;
        seen.kind      = in_if.block_type;
        seen.src_a     = in_if.source_a;
        seen.src_b     = in_if.source_b;
        seen.io        = in_if.io_index;
        seen.preset_ms = in_if.preset_ms;
        seen.scan_ms   = in_if.now_ms;
        seen.inputs    = in_if.input_bits;
        want = eval_block(seen);
        if (fix_en) want = fix_want;
        pending_results.push_back(want);
      end
    end
  end

  // output backpressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 11);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_block(input blk_t b, input logic fixed, input result_t want);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.block_index <= b.slot;
    in_if.block_type  <= b.kind;
    in_if.source_a    <= b.src_a;
    in_if.source_b    <= b.src_b;
    in_if.io_index    <= b.io;
    in_if.preset_ms   <= b.preset_ms;
    in_if.now_ms      <= b.scan_ms;
    in_if.input_bits  <= b.inputs;
    fix_en            <= fixed;
    fix_want          <= want;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // only while idle: drain, let the pipe settle, then write
  task automatic set_count(input logic [CountW-1:0] cnt);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.block_count <= cnt;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [SrcW-1:0] pick_src(input int i, input int n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55 && i > 0) return SrcW'($urandom_range(0, i - 1));
    if (r < 85) return SrcW'($urandom_range(0, n - 1));
    if (r < 92) return '1;
    return SrcW'($urandom_range(0, 63));
  endfunction

  initial begin
    blk_t             b;
    int               prog_n;
    int               sent;
    logic [TimeW-1:0] now_t;
    logic [IoBits-1:0] in_t;
    int               r;

    rst_n              = 1'b0;
    mismatch_count     = 0;
    idle_pct           = 20;
    stall_pct          = 20;
    stall_left         = 0;
    fix_en             = 1'b0;
    fix_want           = '0;
    in_if.valid        = 1'b0;
    in_if.block_index  = '0;
    in_if.block_type   = '0;
    in_if.source_a     = '0;
    in_if.source_b     = '0;
    in_if.io_index     = '0;
    in_if.preset_ms    = '0;
    in_if.now_ms       = '0;
    in_if.input_bits   = '0;
    out_if.ready       = 1'b1;
    cfg_if.valid       = 1'b0;
    cfg_if.block_count = '0;
    out_reg            = '0;
    load_count('0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NumDirRows; i++) begin
      if (i == CountRow) set_count(6'd32);
      send_block(DirRows[i].blk, DirRows[i].fixed, DirRows[i].want);
    end

    // each phase scans a small random program repeatedly with advancing time
    for (int p = 0; p < NumPhases; p++) begin
      set_count(PhaseCount[p]);
      idle_pct  = PhaseIdle[p];
      stall_pct = PhaseStall[p];
      if (PhaseCount[p] >= 1 && PhaseCount[p] <= 12) prog_n = int'(PhaseCount[p]);
      else prog_n = $urandom_range(4, 12);
      for (int i = 0; i < prog_n; i++) begin
        prog[i].slot = ($urandom_range(0, 9) < 8) ? SlotW'(i) : SlotW'($urandom_range(0, 31));
        r = $urandom_range(0, 99);
        if (r < 25)      prog[i].kind = $urandom_range(0, 1) ? KIND_TON : KIND_TOF;
        else if (r < 92) prog[i].kind = KindW'($urandom_range(0, 11));
        else             prog[i].kind = KindW'($urandom_range(12, 15));
        prog[i].src_a = pick_src(i, prog_n);
        prog[i].src_b = pick_src(i, prog_n);
        prog[i].io    = IoW'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 70)      prog[i].preset_ms = $urandom_range(0, 60);
        else if (r < 85) prog[i].preset_ms = '0;
        else             prog[i].preset_ms = $urandom();
      end
      now_t = (p == 3) ? 32'hFFFF_FFC0 : $urandom();
      in_t  = IoBits'($urandom_range(0, 255));
      sent  = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(0, 9) == 0) now_t += $urandom();
        else now_t += $urandom_range(0, 25);
        if ($urandom_range(0, 2) == 0) in_t ^= IoBits'($urandom_range(1, 255));
        for (int i = 0; i < prog_n; i++) begin
          if ($urandom_range(0, 99) < 12) begin
            b.slot      = SlotW'($urandom_range(0, 31));
            b.kind      = KindW'($urandom_range(0, 15));
            b.src_a     = SrcW'($urandom_range(0, 63));
            b.src_b     = SrcW'($urandom_range(0, 63));
            b.io        = IoW'($urandom_range(0, 7));
            b.preset_ms = $urandom();
            b.scan_ms   = $urandom();
            b.inputs    = IoBits'($urandom_range(0, 255));
          end else begin
            b         = prog[i];
            b.scan_ms = now_t;
            b.inputs  = in_t;
          end
          send_block(b, 1'b0, '0);
          sent++;
        end
      end
    end

    in_if.valid <= 1'b0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("ladder_logic_block_evaluator_core test passed");
    end else begin
      $display("ladder_logic_block_evaluator_core test failed");
    end
    $finish;
  end

endmodule
